// ===== rtl/core/vl7p_pkg.sv =====
// ============================================================================
// vl7p_pkg - shared types and constants of the 7-point volume Laplacian
// Sizes, payload structs, register indexes and the divide-by-six reciprocal.
// ============================================================================
package vl7p_pkg;

	localparam int MAX_EXTENT  = 64;
	localparam int SAMPLE_BITS = 16;
	localparam int MIN_EXTENT  = 3;
	localparam int SIZE_RESET  = 64;

	localparam int EXT_W       = $clog2(MAX_EXTENT + 1);
	localparam int IDX_W       = $clog2(MAX_EXTENT);
	localparam int ADDR_W      = 2 * IDX_W + 1;
	localparam int STORE_DEPTH = 2 ** ADDR_W;

	localparam int CFG_W     = 7;
	localparam int CFG_IDX_W = 2;

	localparam int RES_W  = SAMPLE_BITS + 1;
	localparam int SUM1_W = SAMPLE_BITS + 2;
	localparam int DIFF_W = SAMPLE_BITS + 4;
	localparam int MAG_W  = SAMPLE_BITS + 3;

	// floor(v / 6) == (v * RECIP) >> RECIP_SHIFT for every v below 2**MAG_W
	localparam int     RECIP_SHIFT = MAG_W + 3;
	localparam int     RECIP_W     = RECIP_SHIFT - 2;
	localparam longint RECIP       = ((longint'(1) << RECIP_SHIFT) + 5) / 6;
	localparam int     PROD_W      = MAG_W + RECIP_W;

	typedef logic [CFG_IDX_W-1:0] cfg_index_t;
	localparam cfg_index_t CFG_SIZE_SLOW = 2'd0;
	localparam cfg_index_t CFG_SIZE_MID  = 2'd1;
	localparam cfg_index_t CFG_SIZE_FAST = 2'd2;

	typedef logic [ADDR_W-1:0] addr_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic                          flush;
	} voxel_t;

	typedef struct packed {
		logic signed [RES_W-1:0] laplacian;
		logic                    final_voxel;
	} result_t;

	typedef struct packed {
		logic has_result;
		logic interior;
		logic last;
		logic x_zero;
	} scan_info_t;

	typedef struct packed {
		addr_t wr;
		addr_t east;
		addr_t up;
		addr_t down;
	} store_addr_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] east;
		logic signed [SAMPLE_BITS-1:0] up;
		logic signed [SAMPLE_BITS-1:0] down;
		logic signed [SAMPLE_BITS-1:0] back;
	} store_rd_t;

endpackage

// ===== rtl/core/vl7p_scan.sv =====
// ============================================================================
// vl7p_scan - size registers and raster position of the incoming stream
// Tracks plane, row and column, classifies each request and forms addresses.
// ============================================================================
module vl7p_scan import vl7p_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  cfg_index_t       cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             accept,
	input  logic             flush,
	output logic             load,
	output scan_info_t       info,
	output store_addr_t      addr
);

	function automatic logic [EXT_W-1:0] clamp_size(input logic [CFG_W-1:0] v);
		if (int'(v) < MIN_EXTENT) begin
			return EXT_W'(MIN_EXTENT);
		end else if (int'(v) > MAX_EXTENT) begin
			return EXT_W'(MAX_EXTENT);
		end else begin
			return EXT_W'(v);
		end
	endfunction

	logic [EXT_W-1:0] size_slow_q, size_mid_q, size_fast_q;
	logic [EXT_W-1:0] z_q;
	logic [IDX_W-1:0] y_q, x_q;

	logic             cfg_hit;
	logic             x_wrap, y_wrap, z_wrap, origin;
	logic [EXT_W-1:0] z_n;
	logic [IDX_W-1:0] y_n, x_n;
	logic             oz_par;

	always_comb begin
		cfg_hit = cfg_we && (cfg_index == CFG_SIZE_SLOW || cfg_index == CFG_SIZE_MID ||
			cfg_index == CFG_SIZE_FAST);
		x_wrap  = (EXT_W'(x_q) + EXT_W'(1)) == size_fast_q;
		y_wrap  = (EXT_W'(y_q) + EXT_W'(1)) == size_mid_q;
		z_wrap  = z_q == size_slow_q;
		origin  = (x_q == '0) && (y_q == '0) && (z_q == '0);
		x_n = x_wrap ? '0 : x_q + IDX_W'(1);
		y_n = y_q;
		z_n = z_q;
		if (x_wrap) begin
			y_n = y_wrap ? '0 : y_q + IDX_W'(1);
			if (y_wrap) begin
				z_n = z_wrap ? '0 : z_q + EXT_W'(1);
			end
		end
		// drop padding that arrives while no volume is in progress
		load = accept && !(origin && flush);

		info.has_result = z_q != '0;
		info.interior   = (z_q >= EXT_W'(2)) && (z_q < size_slow_q) &&
			(y_q != '0) && ((EXT_W'(y_q) + EXT_W'(1)) < size_mid_q) &&
			(x_q != '0) && ((EXT_W'(x_q) + EXT_W'(1)) < size_fast_q);
		info.last       = z_wrap && y_wrap && x_wrap;
		info.x_zero     = x_q == '0;

		// the plane one behind lies in the other half of the store
		oz_par    = ~z_q[0];
		addr.wr   = {z_q[0], y_q, x_q};
		addr.east = {oz_par, y_q, x_q + IDX_W'(1)};
		addr.up   = (x_q == '0) ? {oz_par, y_q, IDX_W'(0)} :
			{oz_par, y_q - IDX_W'(1), x_q};
		addr.down = {oz_par, y_q + IDX_W'(1), x_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_slow_q <= clamp_size(CFG_W'(SIZE_RESET));
			size_mid_q  <= clamp_size(CFG_W'(SIZE_RESET));
			size_fast_q <= clamp_size(CFG_W'(SIZE_RESET));
			z_q <= '0;
			y_q <= '0;
			x_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_SIZE_SLOW: size_slow_q <= clamp_size(cfg_data);
					CFG_SIZE_MID:  size_mid_q  <= clamp_size(cfg_data);
					CFG_SIZE_FAST: size_fast_q <= clamp_size(cfg_data);
					default: ;
				endcase
			end
			if (cfg_hit) begin
				z_q <= '0;
				y_q <= '0;
				x_q <= '0;
			end else if (load) begin
				z_q <= z_n;
				y_q <= y_n;
				x_q <= x_n;
			end
		end
	end

	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(EXT_W'(x_q) < size_fast_q) && (EXT_W'(y_q) < size_mid_q) && (z_q <= size_slow_q))
		else $error("scan position outside the configured volume");

	a_size_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		(size_fast_q >= EXT_W'(MIN_EXTENT)) && (size_fast_q <= EXT_W'(MAX_EXTENT)) &&
		(size_mid_q >= EXT_W'(MIN_EXTENT)) && (size_slow_q >= EXT_W'(MIN_EXTENT)))
		else $error("size register outside its clamped range");

	a_wrap_to_origin: assert property (@(posedge clk) disable iff (!arst_n)
		(load && info.last && !cfg_we) |=> origin)
		else $error("position did not return to origin after the flush plane");

endmodule

// ===== rtl/core/vl7p_store.sv =====
// ============================================================================
// vl7p_store - two-plane sample store
// Two identical copies, each one write and two registered reads per cycle.
// ============================================================================
module vl7p_store import vl7p_pkg::*; (
	input  logic                          clk,
	input  logic                          load,
	input  store_addr_t                   addr,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	output store_rd_t                     rd
);

	logic signed [SAMPLE_BITS-1:0] copy_a_q [STORE_DEPTH];
	logic signed [SAMPLE_BITS-1:0] copy_b_q [STORE_DEPTH];
	logic signed [SAMPLE_BITS-1:0] east_q, up_q, down_q, back_q;

	always_ff @(posedge clk) begin
		if (load) begin
			copy_a_q[addr.wr] <= sample;
			east_q <= copy_a_q[addr.east];
			up_q   <= copy_a_q[addr.up];
		end
	end

	// back reads the entry being overwritten: old data, two planes behind
	always_ff @(posedge clk) begin
		if (load) begin
			copy_b_q[addr.wr] <= sample;
			down_q <= copy_b_q[addr.down];
			back_q <= copy_b_q[addr.wr];
		end
	end

	assign rd = '{east: east_q, up: up_q, down: down_q, back: back_q};

endmodule

// ===== rtl/core/vl7p_arith.sv =====
// ============================================================================
// vl7p_arith - stencil window, sum and rounded divide by six
// Elastic pipeline: input, sum, magnitude, product and result registers.
// ============================================================================
module vl7p_arith import vl7p_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  scan_info_t                    info,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  store_rd_t                     rd,
	output logic                          ready,
	output logic                          result_valid,
	input  logic                          result_stall,
	output result_t                       result
);

	localparam logic [RECIP_W-1:0] RECIP_K = RECIP_W'(RECIP);

	logic                          v1_q, v2_q, v3_q, v4_q, out_valid_q;
	logic                          en1, en2, en3, en4, en_out;

	scan_info_t                    info_s1;
	logic signed [SAMPLE_BITS-1:0] sample_s1;
	logic signed [SAMPLE_BITS-1:0] c_q, w_q;

	logic signed [SUM1_W-1:0]      sum1_s2;
	logic signed [DIFF_W-1:0]      sum2_s2;
	logic                          interior_s2, last_s2;

	logic [MAG_W-1:0]              mag_s3;
	logic                          neg_s3, interior_s3, last_s3;

	logic [PROD_W-1:0]             prod_s4;
	logic                          neg_s4, interior_s4, last_s4;

	result_t                       result_q;

	logic signed [SUM1_W-1:0]      sum1_d;
	logic signed [DIFF_W-1:0]      six_c, sum2_d, diff_d;
	logic [DIFF_W-1:0]             abs_d;
	logic [MAG_W-1:0]              mag_d;
	logic [PROD_W-1:0]             prod_d;
	logic [RES_W-1:0]              quot;
	logic signed [RES_W-1:0]       lap_d;

	always_comb begin
		en_out = !out_valid_q || !result_stall;
		en4    = !v4_q || en_out;
		en3    = !v3_q || en4;
		en2    = !v2_q || en3;
		en1    = !v1_q || en2;
		ready  = en1;

		// window: east from the store, centre and west from the column taps
		sum1_d = SUM1_W'(rd.up) + SUM1_W'(rd.down) + SUM1_W'(w_q) + SUM1_W'(rd.east);
		six_c  = (DIFF_W'(c_q) <<< 2) + (DIFF_W'(c_q) <<< 1);
		sum2_d = DIFF_W'(rd.back) + DIFF_W'(sample_s1) - six_c;

		diff_d = DIFF_W'(sum1_s2) + sum2_s2;
		abs_d  = diff_d[DIFF_W-1] ? DIFF_W'(-diff_d) : DIFF_W'(diff_d);
		mag_d  = MAG_W'(abs_d) + MAG_W'(3);

		prod_d = PROD_W'(mag_s3) * PROD_W'(RECIP_K);

		quot   = prod_s4[PROD_W-1 -: RES_W];
		lap_d  = !interior_s4 ? '0 : (neg_s4 ? RES_W'(-quot) : RES_W'(quot));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q        <= 1'b0;
			v2_q        <= 1'b0;
			v3_q        <= 1'b0;
			v4_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en1)    v1_q        <= load;
			if (en2)    v2_q        <= v1_q && info_s1.has_result;
			if (en3)    v3_q        <= v2_q;
			if (en4)    v4_q        <= v3_q;
			if (en_out) out_valid_q <= v4_q;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			info_s1   <= info;
			sample_s1 <= sample;
		end
		// advance the column taps on every item, first-plane ones too
		if (v1_q && en2) begin
			c_q         <= rd.east;
			w_q         <= info_s1.x_zero ? rd.up : c_q;
			sum1_s2     <= sum1_d;
			sum2_s2     <= sum2_d;
			interior_s2 <= info_s1.interior;
			last_s2     <= info_s1.last;
		end
		if (v2_q && en3) begin
			mag_s3      <= mag_d;
			neg_s3      <= diff_d[DIFF_W-1];
			interior_s3 <= interior_s2;
			last_s3     <= last_s2;
		end
		if (v3_q && en4) begin
			prod_s4     <= prod_d;
			neg_s4      <= neg_s3;
			interior_s4 <= interior_s3;
			last_s4     <= last_s3;
		end
		if (v4_q && en_out) begin
			result_q <= '{laplacian: lap_d, final_voxel: last_s4};
		end
	end

	assign result_valid = out_valid_q;
	assign result       = result_q;

endmodule

// ===== rtl/core/volume_laplacian_7point.sv =====
// ============================================================================
// volume_laplacian_7point - streaming 3D seven-point Laplacian
// Raster-order voxel stream in, one rounded stencil result per voxel out.
// ============================================================================
// Voxels enter slowest axis first, innermost axis last, one request per
// cycle when not stalled; the unstalled rate is one voxel per clock, set by
// the two-plane store, which takes one write and four reads per cycle across
// its two copies. Each result follows the request that completes its
// stencil, i.e. one plane later, through the store read, sum, magnitude,
// reciprocal multiply and result registers. Send one plane of flush requests
// after the volume; the result of the last voxel carries final_voxel. Border
// voxels give zero. Any write to a size register restarts the scan at the
// origin; sizes are clamped to 3..64. The store needs no clearing pass.
module volume_laplacian_7point import vl7p_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  cfg_index_t       cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             voxel_valid,
	output logic             voxel_stall,
	input  voxel_t           voxel,
	output logic             result_valid,
	input  logic             result_stall,
	output result_t          result
);

	logic        ready;
	logic        accept;
	logic        load;
	scan_info_t  info;
	store_addr_t addr;
	store_rd_t   rd;

	// hold the source only when the first pipeline stage cannot move
	assign voxel_stall = !ready;
	assign accept      = voxel_valid && ready;

	// position, sizes and addresses for the request now at the input
	vl7p_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.flush     (voxel.flush),
		.load      (load),
		.info      (info),
		.addr      (addr)
	);

	// write the sample, read the neighbours one and two planes back
	vl7p_store u_store (
		.clk    (clk),
		.load   (load),
		.addr   (addr),
		.sample (voxel.sample),
		.rd     (rd)
	);

	// form the stencil, divide by six, round and deliver
	vl7p_arith u_arith (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (load),
		.info         (info),
		.sample       (voxel.sample),
		.rd           (rd),
		.ready        (ready),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule
